@@ rtl/pal_pkg.sv @@
// Shared types, widths and codes of the positional array list.
`default_nettype none

package pal_pkg;

   localparam int DEPTH    = 16;
   localparam int IDX_W    = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int CMP_W    = ((CNT_W > 8) ? CNT_W : 8) + 1;

   localparam int OP_W     = 2;
   localparam int POS_W    = 8;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd3;

   typedef struct packed {
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
   } pair_type;

   // Per-cycle command broadcast to every cell. Shift ranges are [lo, hi).
   typedef struct packed {
      logic             load;
      logic [IDX_W-1:0] load_idx;
      logic             from_left;
      logic             from_right;
      logic [CMP_W-1:0] lo;
      logic [CMP_W-1:0] hi;
   } cmd_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  entry_count;
      logic                read_ok;
      logic [IDX_W-1:0]    read_idx;
   } ctl_rsp_type;

endpackage

`default_nettype wire

@@ rtl/pal_if.sv @@
// Request and response channel interfaces of the positional array list.
`default_nettype none

interface pal_req_if;
   logic                                valid;
   logic                                ready;
   logic [pal_pkg::OP_W-1:0]            op;
   logic [pal_pkg::POS_W-1:0]           position;
   logic signed [pal_pkg::DATA_W-1:0]   new_x;
   logic signed [pal_pkg::DATA_W-1:0]   new_y;

   modport source (output valid, op, position, new_x, new_y, input ready);
   modport sink   (input valid, op, position, new_x, new_y, output ready);
endinterface

interface pal_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [pal_pkg::STATUS_W-1:0]        status;
   logic signed [pal_pkg::DATA_W-1:0]   read_x;
   logic signed [pal_pkg::DATA_W-1:0]   read_y;
   logic [pal_pkg::COUNT_W-1:0]         entry_count;

   modport source (output valid, status, read_x, read_y, entry_count, input ready);
   modport sink   (input valid, status, read_x, read_y, entry_count, output ready);
endinterface

`default_nettype wire

@@ rtl/pal_cell.sv @@
// One storage cell of the list: holds a pair, loads it or takes a neighbor's.
`default_nettype none

module pal_cell (
   input  wire logic                      clock,
   input  wire logic [pal_pkg::IDX_W-1:0] cell_idx,
   input  wire pal_pkg::cmd_type          cmd,
   input  wire pal_pkg::pair_type         new_pair,
   input  wire pal_pkg::pair_type         left_pair,
   input  wire pal_pkg::pair_type         right_pair,
   output pal_pkg::pair_type              pair_q
);

   localparam int CW = pal_pkg::CMP_W;

   pal_pkg::pair_type pair_ff;
   pal_pkg::pair_type pair_in;
   logic [CW-1:0]     wide_idx;
   logic              in_range;

   assign wide_idx = CW'(cell_idx);
   assign in_range = (wide_idx >= cmd.lo) && (wide_idx < cmd.hi);

   always_comb begin
      pair_in = pair_ff;
      if (cmd.load && (cell_idx == cmd.load_idx)) begin
         pair_in = new_pair;
      end else if (cmd.from_left && in_range) begin
         pair_in = left_pair;
      end else if (cmd.from_right && in_range) begin
         pair_in = right_pair;
      end
   end

   always_ff @(posedge clock) begin
      pair_ff <= pair_in;
   end

   assign pair_q = pair_ff;

endmodule

`default_nettype wire

@@ rtl/pal_ctrl.sv @@
// Index bookkeeping and per-beat decode: status, count and the cell command.
`default_nettype none

module pal_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      accept,
   input  wire logic [pal_pkg::OP_W-1:0]  op,
   input  wire logic [pal_pkg::POS_W-1:0] position,
   output pal_pkg::cmd_type               cmd,
   output pal_pkg::ctl_rsp_type           rsp_info
);

   localparam int CW = pal_pkg::CMP_W;
   localparam int IW = pal_pkg::IDX_W;

   logic [IW-1:0] first_ff, first_in;
   logic [IW-1:0] last_ff, last_in;
   logic          empty_ff, empty_in;

   pal_pkg::cmd_type cmd_raw;

   logic [CW-1:0] w_first, w_last, w_pos, w_n, p, q, n_next;
   logic          full, pos_ins_ok, pos_in_list, near_left;

   assign w_first     = CW'(first_ff);
   assign w_last      = CW'(last_ff);
   assign w_pos       = CW'(position);
   assign w_n         = empty_ff ? '0 : (w_last - w_first + CW'(1));
   assign full        = !empty_ff && (first_ff == '0) && (last_ff == IW'(pal_pkg::DEPTH - 1));
   assign p           = w_first + w_pos - CW'(1);
   assign q           = p - CW'(1);
   assign pos_ins_ok  = (w_pos != '0) && (w_pos <= w_n + CW'(1));
   assign pos_in_list = (w_pos != '0) && (w_pos <= w_n);
   // The gap is nearer the front when twice the position does not pass the count.
   assign near_left   = ({w_pos, 1'b0} <= {1'b0, w_n});

   always_comb begin
      first_in         = first_ff;
      last_in          = last_ff;
      empty_in         = empty_ff;
      cmd_raw          = '0;
      rsp_info.status  = pal_pkg::ST_BADPOS;
      rsp_info.read_ok = 1'b0;
      rsp_info.read_idx = p[IW-1:0];
      unique case (op)
         pal_pkg::OP_INSERT: begin
            if (full) begin
               rsp_info.status = pal_pkg::ST_FULL;
            end else if (pos_ins_ok) begin
               rsp_info.status = pal_pkg::ST_OK;
               if (empty_ff) begin
                  cmd_raw.load     = 1'b1;
                  cmd_raw.load_idx = '0;
                  first_in         = '0;
                  last_in          = '0;
                  empty_in         = 1'b0;
               end else if ((first_ff == '0) ||
                            ((last_ff != IW'(pal_pkg::DEPTH - 1)) && !near_left)) begin
                  cmd_raw.load      = 1'b1;
                  cmd_raw.load_idx  = p[IW-1:0];
                  cmd_raw.from_left = 1'b1;
                  cmd_raw.lo        = p + CW'(1);
                  cmd_raw.hi        = w_last + CW'(2);
                  last_in           = last_ff + IW'(1);
               end else begin
                  cmd_raw.load       = 1'b1;
                  cmd_raw.load_idx   = q[IW-1:0];
                  cmd_raw.from_right = 1'b1;
                  cmd_raw.lo         = w_first - CW'(1);
                  cmd_raw.hi         = q;
                  first_in           = first_ff - IW'(1);
               end
            end
         end
         pal_pkg::OP_REMOVE: begin
            if (empty_ff) begin
               rsp_info.status = pal_pkg::ST_EMPTY;
            end else if (pos_in_list) begin
               rsp_info.status = pal_pkg::ST_OK;
               if (w_n == CW'(1)) begin
                  empty_in = 1'b1;
                  first_in = '0;
                  last_in  = '0;
               end else if (w_pos == CW'(1)) begin
                  first_in = first_ff + IW'(1);
               end else if (w_pos == w_n) begin
                  last_in = last_ff - IW'(1);
               end else if (near_left) begin
                  cmd_raw.from_left = 1'b1;
                  cmd_raw.lo        = w_first + CW'(1);
                  cmd_raw.hi        = p + CW'(1);
                  first_in          = first_ff + IW'(1);
               end else begin
                  cmd_raw.from_right = 1'b1;
                  cmd_raw.lo         = p;
                  cmd_raw.hi         = w_last;
                  last_in            = last_ff - IW'(1);
               end
            end
         end
         pal_pkg::OP_READ: begin
            if (empty_ff) begin
               rsp_info.status = pal_pkg::ST_EMPTY;
            end else if (pos_in_list) begin
               rsp_info.status  = pal_pkg::ST_OK;
               rsp_info.read_ok = 1'b1;
            end
         end
         default: begin
            rsp_info.status = pal_pkg::ST_BADPOS;
         end
      endcase
      n_next = empty_in ? '0 : (CW'(last_in) - CW'(first_in) + CW'(1));
      rsp_info.entry_count = n_next[pal_pkg::COUNT_W-1:0];
   end

   always_comb begin
      cmd            = cmd_raw;
      cmd.load       = cmd_raw.load && accept;
      cmd.from_left  = cmd_raw.from_left && accept;
      cmd.from_right = cmd_raw.from_right && accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= '0;
         last_ff  <= '0;
         empty_ff <= 1'b1;
      end else if (accept) begin
         first_ff <= first_in;
         last_ff  <= last_in;
         empty_ff <= empty_in;
      end
   end

   a_empty_indices: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (first_ff == '0) && (last_ff == '0))
      else $error("empty list with nonzero indices");

   a_index_order: assert property (@(posedge clock) disable iff (reset)
      first_ff <= last_ff)
      else $error("first index passed last index");

   a_reject_holds: assert property (@(posedge clock) disable iff (reset)
      accept && (rsp_info.status != pal_pkg::ST_OK) |=>
         $stable(first_ff) && $stable(last_ff) && $stable(empty_ff))
      else $error("rejected beat changed the list");

   a_insert_fills: assert property (@(posedge clock) disable iff (reset)
      accept && (op == pal_pkg::OP_INSERT) && (rsp_info.status == pal_pkg::ST_OK) |=>
         !empty_ff)
      else $error("list empty after a good insert");

endmodule

`default_nettype wire

@@ rtl/positional_array_list_top.sv @@
// Top level of the positional array list: control, row of cells, response register.
// Throughput is one beat per cycle while responses are taken: any shift of the list
// moves every affected cell by one place in the same cycle, so no operation iterates.
// The response lands in an output register at the accepting edge.
// A new beat is taken while a response waits, as long as the response is being taken.
// Synchronous reset empties the list and zeroes both indices; cell contents are left
// undefined and there is no clearing pass, since an empty list never reads them.
`default_nettype none

module positional_array_list_top (
   input  wire logic  clock,
   input  wire logic  reset,
   pal_req_if.sink    req_bus,
   pal_rsp_if.source  rsp_bus
);

   localparam int DEPTH = pal_pkg::DEPTH;
   localparam int IW    = pal_pkg::IDX_W;

   // The request side stalls only when a response is held and not being taken.
   logic rsp_valid_ff;
   logic accept;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   pal_pkg::cmd_type     cmd;
   pal_pkg::ctl_rsp_type rsp_info;
   pal_pkg::pair_type    new_pair;
   pal_pkg::pair_type    cell_q [DEPTH];
   pal_pkg::pair_type    read_pair;

   assign new_pair.x = req_bus.new_x;
   assign new_pair.y = req_bus.new_y;

   // The controller owns the first and last index and the empty flag. It
   // decides status and new count and broadcasts one command to the cells.
   pal_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .op       (req_bus.op),
      .position (req_bus.position),
      .cmd      (cmd),
      .rsp_info (rsp_info)
   );

   // The row of cells. Each cell sees both neighbors; the end cells see
   // themselves in place of the missing neighbor, which no command selects.
   for (genvar c = 0; c < DEPTH; c++) begin : g_cell
      pal_pkg::pair_type left_pair;
      pal_pkg::pair_type right_pair;

      if (c == 0) begin : g_left_edge
         assign left_pair = cell_q[c];
      end else begin : g_left
         assign left_pair = cell_q[c-1];
      end

      if (c == DEPTH - 1) begin : g_right_edge
         assign right_pair = cell_q[c];
      end else begin : g_right
         assign right_pair = cell_q[c+1];
      end

      pal_cell u_cell (
         .clock      (clock),
         .cell_idx   (IW'(c)),
         .cmd        (cmd),
         .new_pair   (new_pair),
         .left_pair  (left_pair),
         .right_pair (right_pair),
         .pair_q     (cell_q[c])
      );
   end

   // A read takes the cell contents before this beat's update, which a read
   // never changes anyway. Anything but a good read returns zeros.
   assign read_pair = cell_q[rsp_info.read_idx];

   logic [pal_pkg::STATUS_W-1:0]      status_ff;
   logic signed [pal_pkg::DATA_W-1:0] read_x_ff;
   logic signed [pal_pkg::DATA_W-1:0] read_y_ff;
   logic [pal_pkg::COUNT_W-1:0]       count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Payload registers load with every accepted beat and need no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= rsp_info.status;
         read_x_ff <= rsp_info.read_ok ? read_pair.x : '0;
         read_y_ff <= rsp_info.read_ok ? read_pair.y : '0;
         count_ff  <= rsp_info.entry_count;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.read_x      = read_x_ff;
   assign rsp_bus.read_y      = read_y_ff;
   assign rsp_bus.entry_count = count_ff;

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for the positional array list top level.
`timescale 1ns / 100ps

module tb_top;
   import pal_pkg::*;

   // The op code that the block does not define; it must answer with a bad position.
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   localparam int RANDOM_ITEMS   = 1825;  // random beats after the directed opening
   localparam int QUIET_ITEMS    = 150;   // closing beats that run without any idling
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either channel
   localparam int DRAIN_CYCLES   = 8;     // settle time after the last response
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] new_x;
      logic signed [DATA_W-1:0] new_y;
   } list_cmd_t;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic signed [DATA_W-1:0] read_x;
      logic signed [DATA_W-1:0] read_y;
      logic [COUNT_W-1:0]       entry_count;
   } list_rsp_t;

   logic clock = 1'b0;
   logic reset;

   pal_req_if req_bus();
   pal_rsp_if rsp_bus();

   positional_array_list_top u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #1 clock = ~clock;

   // Commands waiting to be driven, and the responses the list model says must come back.
   list_cmd_t cmd_q[$];
   list_rsp_t list_rsp_q[$];
   list_cmd_t cur_cmd;

   int total_items;
   int beats_sent;
   int rsps_seen;
   int mismatch_count;
   int stall_cycles;
   int fill_count;  // entry count tracked while building the stimulus
   int fill_goal;   // fill level that the well-formed random traffic steers toward

   // Idling state of both channels. Each side re-rolls how often it idles every
   // 64 beats, so there are stretches of heavy idling and stretches with none.
   int req_gap;
   int rsp_gap;
   int req_idle_pct;
   int rsp_idle_pct;

   // The model of the list: the cell array and the first and last occupied cells.
   logic signed [DATA_W-1:0] cell_x [DEPTH];
   logic signed [DATA_W-1:0] cell_y [DEPTH];
   int  head_idx = 0;
   int  tail_idx = 0;
   bit  is_empty = 1'b1;

   function automatic int list_held();
      return is_empty ? 0 : tail_idx - head_idx + 1;
   endfunction

   // Open a hole at cell p by moving cells p..tail up one place.
   task automatic open_up(input int p);
      int c;
      for (c = tail_idx + 1; c > p; c--) begin
         cell_x[c] = cell_x[c-1];
         cell_y[c] = cell_y[c-1];
      end
      tail_idx++;
   endtask

   // Open a hole at cell p by moving cells head..p down one place.
   task automatic open_down(input int p);
      int c;
      for (c = head_idx; c <= p; c++) begin
         cell_x[c-1] = cell_x[c];
         cell_y[c-1] = cell_y[c];
      end
      head_idx--;
   endtask

   // Apply one command to the list model and return the response it must produce.
   task automatic list_apply(input list_cmd_t cmd, output list_rsp_t rsp);
      int n;
      int pos;
      int p;
      int c;
      n   = list_held();
      pos = int'(cmd.position);
      rsp = '0;
      case (cmd.op)
         OP_INSERT: begin
            if (!is_empty && head_idx == 0 && tail_idx == DEPTH - 1) begin
               rsp.status = ST_FULL;
            end else if (pos < 1 || pos > n + 1) begin
               rsp.status = ST_BADPOS;
            end else begin
               if (is_empty) begin
                  head_idx = 0;
                  tail_idx = 0;
                  is_empty = 1'b0;
                  p = 0;
               end else begin
                  p = head_idx + pos - 1;
                  // Touching cell 0 forces an upward shift, touching the top cell a
                  // downward one; otherwise the shorter side moves. The hole may sit
                  // one past the tail, so the distances are signed.
                  if (head_idx == 0) begin
                     open_up(p);
                  end else if (tail_idx == DEPTH - 1) begin
                     p--;
                     open_down(p);
                  end else if (p - head_idx < tail_idx - p) begin
                     p--;
                     open_down(p);
                  end else begin
                     open_up(p);
                  end
               end
               cell_x[p] = cmd.new_x;
               cell_y[p] = cmd.new_y;
               rsp.status = ST_OK;
            end
         end
         OP_REMOVE: begin
            if (is_empty) begin
               rsp.status = ST_EMPTY;
            end else if (pos < 1 || pos > n) begin
               rsp.status = ST_BADPOS;
            end else begin
               rsp.status = ST_OK;
               if (n == 1) begin
                  is_empty = 1'b1;
                  head_idx = 0;
                  tail_idx = 0;
               end else if (pos == 1) begin
                  head_idx++;
               end else if (pos == n) begin
                  tail_idx--;
               end else begin
                  p = head_idx + pos - 1;
                  if (p - head_idx < tail_idx - p) begin
                     for (c = p; c > head_idx; c--) begin
                        cell_x[c] = cell_x[c-1];
                        cell_y[c] = cell_y[c-1];
                     end
                     head_idx++;
                  end else begin
                     for (c = p; c < tail_idx; c++) begin
                        cell_x[c] = cell_x[c+1];
                        cell_y[c] = cell_y[c+1];
                     end
                     tail_idx--;
                  end
               end
            end
         end
         OP_READ: begin
            if (is_empty) begin
               rsp.status = ST_EMPTY;
            end else if (pos < 1 || pos > n) begin
               rsp.status = ST_BADPOS;
            end else begin
               p = head_idx + pos - 1;
               rsp.read_x = cell_x[p];
               rsp.read_y = cell_y[p];
               rsp.status = ST_OK;
            end
         end
         default: begin
            rsp.status = ST_BADPOS;
         end
      endcase
      rsp.entry_count = COUNT_W'(list_held());
   endtask

   // Queue one command and track the entry count it leaves behind, so that the
   // random part can aim its positions at the current list.
   task automatic queue_cmd(input logic [OP_W-1:0] op, input int pos,
                            input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] y);
      list_cmd_t cmd;
      cmd.op       = op;
      cmd.position = POS_W'(pos);
      cmd.new_x    = x;
      cmd.new_y    = y;
      cmd_q.push_back(cmd);
      if (op == OP_INSERT && fill_count < DEPTH && pos >= 1 && pos <= fill_count + 1) begin
         fill_count++;
      end else if (op == OP_REMOVE && pos >= 1 && pos <= fill_count) begin
         fill_count--;
      end
   endtask

   // Mostly uniform data words, with the extremes of the signed range mixed in.
   function automatic logic [DATA_W-1:0] rand_word();
      case ($urandom_range(0, 15))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom();
      endcase
   endfunction

   // A valid position in 1..n, leaning toward the two ends of the list.
   function automatic int pick_pos(input int n);
      case ($urandom_range(0, 3))
         0:       return 1;
         1:       return n;
         default: return $urandom_range(1, n);
      endcase
   endfunction

   function automatic int pick_idle_pct();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 10;
         2:       return 30;
         default: return 60;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input longint due, input longint seen);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
         $display("Mismatch on response %0d, %s: expected %0d, got %0d",
                  rsps_seen, what, due, seen);
      end
   endtask

   // Request driver. A new beat, or an idle burst, is chosen only when the channel
   // is free, so valid never drops before its beat is taken.
   always @(posedge clock) begin
      list_rsp_t due;
      logic      next_valid;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         next_valid = req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            list_apply(cur_cmd, due);
            list_rsp_q.push_back(due);
            beats_sent++;
            next_valid = 1'b0;
            if (beats_sent % 64 == 0) begin
               req_idle_pct = pick_idle_pct();
            end
         end
         if (!next_valid && cmd_q.size() > 0) begin
            if (req_gap > 0) begin
               req_gap--;
            end else if (cmd_q.size() >= QUIET_ITEMS &&
                         $urandom_range(0, 99) < req_idle_pct) begin
               req_gap = $urandom_range(0, 12);
            end else begin
               cur_cmd = cmd_q.pop_front();
               next_valid = 1'b1;
               req_bus.op       <= cur_cmd.op;
               req_bus.position <= cur_cmd.position;
               req_bus.new_x    <= cur_cmd.new_x;
               req_bus.new_y    <= cur_cmd.new_y;
            end
         end
         req_bus.valid <= next_valid;
      end
   end

   // Response monitor. Each beat is checked field by field against the oldest
   // expectation; ready stalls in bursts until the quiet end.
   always @(posedge clock) begin
      list_rsp_t seen;
      list_rsp_t due;
      logic      next_ready;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.status      = rsp_bus.status;
            seen.read_x      = rsp_bus.read_x;
            seen.read_y      = rsp_bus.read_y;
            seen.entry_count = rsp_bus.entry_count;
            if (list_rsp_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("Response beat with nothing expected: status %0d count %0d",
                           seen.status, seen.entry_count);
               end
            end else begin
               due = list_rsp_q.pop_front();
               if (seen.status !== due.status) begin
                  report_mismatch("status", due.status, seen.status);
               end
               if (seen.read_x !== due.read_x) begin
                  report_mismatch("read_x", due.read_x, seen.read_x);
               end
               if (seen.read_y !== due.read_y) begin
                  report_mismatch("read_y", due.read_y, seen.read_y);
               end
               if (seen.entry_count !== due.entry_count) begin
                  report_mismatch("entry_count", due.entry_count, seen.entry_count);
               end
            end
            rsps_seen++;
            if (rsps_seen % 64 == 0) begin
               rsp_idle_pct = pick_idle_pct();
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            next_ready = 1'b0;
         end else if (cmd_q.size() >= QUIET_ITEMS &&
                      $urandom_range(0, 99) < rsp_idle_pct) begin
            rsp_gap = $urandom_range(0, 12);
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
         end
         rsp_bus.ready <= next_ready;
      end
   end

   // Watchdog: counts cycles in which neither channel moves a beat.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int  i;
      int  roll;
      int  pos;
      logic [OP_W-1:0] op;
      bit  timed_out;

      req_bus.valid    = 1'b0;
      req_bus.op       = OP_READ;
      req_bus.position = '0;
      req_bus.new_x    = '0;
      req_bus.new_y    = '0;
      rsp_bus.ready    = 1'b0;
      reset            = 1'b1;
      beats_sent       = 0;
      rsps_seen        = 0;
      mismatch_count   = 0;
      stall_cycles     = 0;
      fill_count       = 0;
      fill_goal        = 0;
      req_gap          = 0;
      rsp_gap          = 0;
      req_idle_pct     = 0;
      rsp_idle_pct     = 0;
      for (i = 0; i < DEPTH; i++) begin
         cell_x[i] = '0;
         cell_y[i] = '0;
      end

      // Directed opening: every operation on the empty list, the unused op, an
      // insert at position zero, a single entry taken out again, a fill to the
      // top with extreme data, inserts into the full list, a read far out of
      // range, and removes at the last, first and an inner position.
      queue_cmd(OP_READ,   1, '0, '0);
      queue_cmd(OP_REMOVE, 1, '0, '0);
      queue_cmd(OP_INSERT, 0, 32'h1234_5678, 32'h9ABC_DEF0);
      queue_cmd(OP_UNUSED, 1, '0, '0);
      queue_cmd(OP_INSERT, 1, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_cmd(OP_REMOVE, 1, '0, '0);
      for (i = 0; i < DEPTH; i++) begin
         queue_cmd(OP_INSERT, (i % 2 == 0) ? 1 : fill_count + 1,
                   (i % 4 < 2) ? 32'h8000_0000 : 32'h7FFF_FFFF,
                   (i % 3 == 0) ? 32'hFFFF_FFFF : $urandom());
      end
      queue_cmd(OP_INSERT, DEPTH + 1, 32'h0000_0001, 32'h0000_0002);
      queue_cmd(OP_INSERT, 1, 32'h0000_0003, 32'h0000_0004);
      queue_cmd(OP_READ,   255, '0, '0);
      queue_cmd(OP_REMOVE, DEPTH, '0, '0);
      queue_cmd(OP_REMOVE, 1, '0, '0);
      queue_cmd(OP_REMOVE, 5, '0, '0);

      // Random part. Most beats are well formed and steer the fill level toward a
      // goal that moves every 40 beats, so the list runs through empty, full and
      // everything between, with the occupied window drifting across the array.
      // The rest is noise over the whole field range and positions just outside
      // the valid window.
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 40 == 0) begin
            case ($urandom_range(0, 3))
               0:       fill_goal = 0;
               1:       fill_goal = DEPTH;
               default: fill_goal = $urandom_range(0, DEPTH);
            endcase
         end
         roll = $urandom_range(0, 99);
         if (roll < 6) begin
            op  = OP_W'($urandom_range(0, 3));
            pos = $urandom_range(0, 255);
         end else if (roll < 12) begin
            op  = OP_W'($urandom_range(0, 2));
            pos = $urandom_range(0, 1) ? 0 : fill_count + 1 + ((op == OP_INSERT) ? 1 : 0);
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 20) begin
               op = OP_READ;
            end else if (fill_count < fill_goal) begin
               op = (roll < 85) ? OP_INSERT : OP_REMOVE;
            end else if (fill_count > fill_goal) begin
               op = (roll < 35) ? OP_INSERT : OP_REMOVE;
            end else begin
               op = (roll < 60) ? OP_INSERT : OP_REMOVE;
            end
            if (op == OP_INSERT) begin
               pos = pick_pos(fill_count + 1);
            end else begin
               pos = (fill_count == 0) ? 1 : pick_pos(fill_count);
            end
         end
         queue_cmd(op, pos, rand_word(), rand_word());
      end
      total_items = cmd_q.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Run until every beat has been sent and answered, or the watchdog trips.
      while (!(beats_sent == total_items && list_rsp_q.size() == 0) &&
             stall_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
      end
      timed_out = (stall_cycles >= WATCHDOG_LIMIT);
      // A short drain catches any stray response beat after the last expected one.
      if (!timed_out) begin
         repeat (DRAIN_CYCLES) @(posedge clock);
      end

      if (!timed_out && mismatch_count == 0 && list_rsp_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/pal_pkg.sv
rtl/pal_if.sv
rtl/pal_cell.sv
rtl/pal_ctrl.sv
rtl/positional_array_list_top.sv
sim/tb_top.sv
